[src/fmfe_pkg.sv]
// fmfe_pkg: shared types, slot constants and the elaboration-time cosine
// generator for the fourier mode forcing evaluator. no dependencies.
package fmfe_pkg;

   localparam int NUM_MODES = 3;
   localparam int NUM_COMP  = 3;
   localparam int NUM_SLOTS = NUM_COMP * NUM_MODES;

   localparam int POS_W   = 16;
   localparam int AMP_W   = 16;
   localparam int PHASE_W = 16;
   localparam int SCALE_W = 16;
   localparam int SLOT_W  = 4;
   localparam int COS_W   = 16;   // signed cosine, -16384 .. 16384
   localparam int MAG_W   = 15;   // quarter-wave magnitude, 0 .. 16384
   localparam int PROD_W  = 31;   // amplitude times cosine
   localparam int ACC_W   = 32;   // three products summed
   localparam int WIDE_W  = 48;   // sum times scale
   localparam int ACCEL_W = 20;
   localparam int ACCEL_LSB = 28;

   localparam logic [SCALE_W-1:0] DRIVE_SCALE_RESET = 16'd11045;

   localparam logic KIND_EVAL = 1'b0;
   localparam logic KIND_LOAD = 1'b1;

   // mode axis of each slot, and slots whose component equals the mode axis
   localparam int SLOT_MODE [NUM_SLOTS] = '{0, 1, 2, 0, 1, 2, 0, 1, 2};
   localparam logic [NUM_SLOTS-1:0] DIAG_MASK = 9'b100010001;

   typedef logic signed [AMP_W-1:0]   amp_type;
   typedef logic [PHASE_W-1:0]        phase_type;
   typedef logic [MAG_W-1:0]          mag_type;
   typedef logic signed [COS_W-1:0]   cos_type;
   typedef logic signed [PROD_W-1:0]  prod_type;
   typedef logic signed [ACC_W-1:0]   acc_type;
   typedef logic signed [ACCEL_W-1:0] accel_type;

   // fixed point with 60 fraction bits
   localparam logic [63:0] FX_ONE     = 64'h1000_0000_0000_0000;
   localparam logic [63:0] FX_HALF_PI = 64'h1921_FB54_442D_1846;
   localparam logic [63:0] FX_ROUND   = 64'h0000_2000_0000_0000;
   localparam logic [63:0] TAYLOR_DIV [14] = '{
      64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182,
      64'd240, 64'd306, 64'd380, 64'd462, 64'd552, 64'd650, 64'd756};

   // approximate (a * b) >> 60 with the low cross carries dropped
   function automatic logic [63:0] fx_mul(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] ah;
      logic [63:0] al;
      logic [63:0] bh;
      logic [63:0] bl;
      logic [63:0] mid;
      ah  = a >> 32;
      al  = a & 64'h0000_0000_FFFF_FFFF;
      bh  = b >> 32;
      bl  = b & 64'h0000_0000_FFFF_FFFF;
      mid = ah * bl + al * bh + ((al * bl) >> 32);
      return ((ah * bh) << 4) + (mid >> 28);
   endfunction

   // round(16384 * cos(pi/2 * u / 2^(idx_bits-2))), taylor series, used at elaboration
   function automatic mag_type cos_quarter(input int u, input int idx_bits);
      int                 qb;
      logic [63:0]        q;
      logic [63:0]        uu;
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic signed [63:0] sum;
      logic [63:0]        r;
      qb   = idx_bits - 2;
      q    = 64'd1 << qb;
      uu   = 64'(u);
      x    = (FX_HALF_PI >> qb) * uu + (((FX_HALF_PI & (q - 64'd1)) * uu) >> qb);
      x2   = fx_mul(x, x);
      term = FX_ONE;
      sum  = $signed(FX_ONE);
      for (int n = 1; n <= 14; n++) begin
         term = fx_mul(term, x2) / TAYLOR_DIV[n-1];
         if (n % 2 == 1) begin
            sum = sum - $signed(term);
         end else begin
            sum = sum + $signed(term);
         end
      end
      if (sum < 0) begin
         sum = '0;
      end
      r = ($unsigned(sum) + FX_ROUND) >> 46;
      return MAG_W'(r);
   endfunction

endpackage

[src/fourier_mode_forcing_eval_top.sv]
// fourier_mode_forcing_eval_top: forcing acceleration from three axis-aligned
// fourier modes, 3x3 coefficient store and a five-stage evaluation pipeline.
// depends on fmfe_pkg.
//
//   channel | ports                                 | moves
//   --------+---------------------------------------+-------------------------------
//   req     | req_valid / req_stall + fields        | evaluate or coefficient load
//   rsp     | rsp_valid / rsp_stall + accel_x/y/z   | one result per gas evaluate
//   csr     | csr_wr_en / csr_wr_data               | drive_scale write
//
// an item can enter every cycle while req_stall is low; a gas evaluate is offered on rsp
// once it has passed angle fold, quarter-wave table, products, sums and scale multiply.
// loads update the store at acceptance and produce no item; later evaluates see them.
// reset clears the store and all valid bits and sets drive_scale to DRIVE_SCALE_RESET.
// each stage holds while the one after it is full and stalled; bubbles close up,
// so req_stall rises only once every stage holds an item.
module fourier_mode_forcing_eval_top
   import fmfe_pkg::*;
#(
   parameter int ANGLE_BITS     = 16,
   parameter int COS_INDEX_BITS = 10
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_kind,
   input  logic [POS_W-1:0]      req_pos_x,
   input  logic [POS_W-1:0]      req_pos_y,
   input  logic [POS_W-1:0]      req_pos_z,
   input  logic                  req_is_gas,
   input  logic [SLOT_W-1:0]     req_coef_slot,
   input  logic signed [AMP_W-1:0] req_coef_amplitude,
   input  logic [PHASE_W-1:0]    req_coef_phase,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic signed [ACCEL_W-1:0] rsp_accel_x,
   output logic signed [ACCEL_W-1:0] rsp_accel_y,
   output logic signed [ACCEL_W-1:0] rsp_accel_z,
   input  logic                  csr_wr_en,
   input  logic [SCALE_W-1:0]    csr_wr_data
);

   localparam int LOW_W   = COS_INDEX_BITS - 2;
   localparam int QUARTER = 1 << LOW_W;
   localparam int EXT_W   = 40;
   localparam int ANG_UP  = (ANGLE_BITS >= POS_W) ? ANGLE_BITS - POS_W : 0;
   localparam int ANG_DN  = (ANGLE_BITS >= POS_W) ? 0 : POS_W - ANGLE_BITS;
   localparam int IDX_UP  = (ANGLE_BITS >= COS_INDEX_BITS) ? 0 : COS_INDEX_BITS - ANGLE_BITS;
   localparam int IDX_DN  = (ANGLE_BITS >= COS_INDEX_BITS) ? ANGLE_BITS - COS_INDEX_BITS : 0;

   // quarter-wave cosine table, built at elaboration
   mag_type cos_rom [QUARTER];
   for (genvar i = 0; i < QUARTER; i++) begin : g_rom
      localparam mag_type ROM_VAL = cos_quarter(i, COS_INDEX_BITS);
      assign cos_rom[i] = ROM_VAL;
   end

   // configuration and coefficient store
   logic [SCALE_W-1:0] drive_scale_ff;
   amp_type            amp_ff   [NUM_SLOTS];
   phase_type          phase_ff [NUM_SLOTS];

   logic req_accept;
   logic load_accept;
   logic eval_accept;

   // pipeline valid bits and stage loads
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, rsp_valid_ff;
   logic ld1, ld2, ld3, ld4, ld_out;

   assign ld_out = !rsp_valid_ff || !rsp_stall;
   assign ld4    = !s4_valid_ff || ld_out;
   assign ld3    = !s3_valid_ff || ld4;
   assign ld2    = !s2_valid_ff || ld3;
   assign ld1    = !s1_valid_ff || ld2;

   assign req_stall   = !ld1;
   assign req_accept  = req_valid && ld1;
   assign load_accept = req_accept && (req_kind == KIND_LOAD);
   assign eval_accept = req_accept && (req_kind == KIND_EVAL) && req_is_gas;

   always_ff @(posedge clock) begin
      if (reset) begin
         drive_scale_ff <= DRIVE_SCALE_RESET;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            amp_ff[i]   <= '0;
            phase_ff[i] <= '0;
         end
      end else begin
         if (csr_wr_en) begin
            drive_scale_ff <= csr_wr_data;
         end
         for (int i = 0; i < NUM_SLOTS; i++) begin
            if (load_accept && (req_coef_slot == SLOT_W'(i))) begin
               amp_ff[i]   <= DIAG_MASK[i] ? '0 : req_coef_amplitude;
               phase_ff[i] <= req_coef_phase;
            end
         end
      end
   end

   // stage 1: angle per slot, folded to a quarter-wave index
   logic [LOW_W-1:0]     s1_idx_in  [NUM_SLOTS];
   logic [NUM_SLOTS-1:0] s1_zero_in;
   logic [NUM_SLOTS-1:0] s1_neg_in;
   logic [LOW_W-1:0]     s1_idx_ff  [NUM_SLOTS];
   logic [NUM_SLOTS-1:0] s1_zero_ff;
   logic [NUM_SLOTS-1:0] s1_neg_ff;
   amp_type              s1_amp_ff  [NUM_SLOTS];

   logic [POS_W-1:0]      pos [NUM_MODES];
   logic [ANGLE_BITS-1:0] pos_ang [NUM_MODES];

   assign pos[0] = req_pos_x;
   assign pos[1] = req_pos_y;
   assign pos[2] = req_pos_z;

   always_comb begin
      logic [ANGLE_BITS-1:0]     ph_ang;
      logic [ANGLE_BITS-1:0]     ang;
      logic [COS_INDEX_BITS-1:0] tix;
      logic [LOW_W-1:0]          low;
      logic                      mirror;
      for (int k = 0; k < NUM_MODES; k++) begin
         pos_ang[k] = ANGLE_BITS'((EXT_W'(pos[k]) << ANG_UP) >> ANG_DN);
      end
      for (int i = 0; i < NUM_SLOTS; i++) begin
         ph_ang = ANGLE_BITS'((EXT_W'(phase_ff[i]) << ANG_UP) >> ANG_DN);
         ang    = pos_ang[SLOT_MODE[i]] + ph_ang;
         tix    = COS_INDEX_BITS'((EXT_W'(ang) << IDX_UP) >> IDX_DN);
         low    = tix[LOW_W-1:0];
         // second and fourth quarters run the table backwards
         mirror = tix[COS_INDEX_BITS-2];
         s1_idx_in[i]  = mirror ? LOW_W'(-low) : low;
         s1_zero_in[i] = mirror && (low == '0);
         s1_neg_in[i]  = tix[COS_INDEX_BITS-1] ^ tix[COS_INDEX_BITS-2];
      end
   end

   // stage 2: table lookup with sign
   cos_type s2_cos_in [NUM_SLOTS];
   cos_type s2_cos_ff [NUM_SLOTS];
   amp_type s2_amp_ff [NUM_SLOTS];

   always_comb begin
      cos_type mag;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         mag          = s1_zero_ff[i] ? '0 : cos_type'(cos_rom[s1_idx_ff[i]]);
         s2_cos_in[i] = s1_neg_ff[i] ? -mag : mag;
      end
   end

   // stage 3: amplitude times cosine
   prod_type s3_prod_in [NUM_SLOTS];
   prod_type s3_prod_ff [NUM_SLOTS];

   always_comb begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
         s3_prod_in[i] = PROD_W'(s2_amp_ff[i]) * PROD_W'(s2_cos_ff[i]);
      end
   end

   // stage 4: sum over modes per component
   acc_type s4_acc_in [NUM_COMP];
   acc_type s4_acc_ff [NUM_COMP];

   always_comb begin
      for (int d = 0; d < NUM_COMP; d++) begin
         s4_acc_in[d] = ACC_W'(s3_prod_ff[d*NUM_MODES])
                      + ACC_W'(s3_prod_ff[d*NUM_MODES+1])
                      + ACC_W'(s3_prod_ff[d*NUM_MODES+2]);
      end
   end

   // output stage: scale, floor shift by 28
   accel_type rsp_accel_in [NUM_COMP];
   accel_type rsp_accel_ff [NUM_COMP];

   always_comb begin
      logic signed [WIDE_W-1:0] wide;
      for (int d = 0; d < NUM_COMP; d++) begin
         wide = WIDE_W'(s4_acc_ff[d]) * $signed(WIDE_W'(drive_scale_ff));
         rsp_accel_in[d] = wide[ACCEL_LSB+ACCEL_W-1:ACCEL_LSB];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (ld1) begin
            s1_valid_ff <= eval_accept;
         end
         if (ld2) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (ld3) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (ld4) begin
            s4_valid_ff <= s3_valid_ff;
         end
         if (ld_out) begin
            rsp_valid_ff <= s4_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ld1) begin
         s1_zero_ff <= s1_zero_in;
         s1_neg_ff  <= s1_neg_in;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            s1_idx_ff[i] <= s1_idx_in[i];
            s1_amp_ff[i] <= amp_ff[i];
         end
      end
      if (ld2) begin
         for (int i = 0; i < NUM_SLOTS; i++) begin
            s2_cos_ff[i] <= s2_cos_in[i];
            s2_amp_ff[i] <= s1_amp_ff[i];
         end
      end
      if (ld3) begin
         for (int i = 0; i < NUM_SLOTS; i++) begin
            s3_prod_ff[i] <= s3_prod_in[i];
         end
      end
      if (ld4) begin
         for (int d = 0; d < NUM_COMP; d++) begin
            s4_acc_ff[d] <= s4_acc_in[d];
         end
      end
      if (ld_out) begin
         for (int d = 0; d < NUM_COMP; d++) begin
            rsp_accel_ff[d] <= rsp_accel_in[d];
         end
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_accel_x = rsp_accel_ff[0];
   assign rsp_accel_y = rsp_accel_ff[1];
   assign rsp_accel_z = rsp_accel_ff[2];

endmodule
